@@ sv/cmer_pkg.sv @@
// Package for the class-marked event ring: sizes, command and register codes,
// record and mask layouts, and the ring index step.
// No dependencies.
`default_nettype none
package cmer_pkg;

	localparam int DEPTH = 64;
	localparam int CLASSES = 8;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int STEP_W = $clog2(DEPTH + 1);
	localparam int MASK_W = 8;
	localparam int THR_W = 7;
	localparam int PC_W = 2;
	localparam int CMP_W = (IDX_W > THR_W) ? IDX_W : THR_W;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAVE_THRESHOLD = 1'd1;

	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_START = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [31:0] device;
		logic [7:0] etype;
		logic [7:0] first;
		logic [7:0] second;
		logic [47:0] clock;
	} rec_t;

	typedef struct packed {
		logic [MASK_W-1:0] last;
		logic [MASK_W-1:0] first;
	} mask_pair_t;

	typedef struct packed {
		logic [PC_W-1:0] partition_count;
		logic [THR_W-1:0] save_threshold;
	} cfg_t;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage
`default_nettype wire

@@ sv/cmer_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module cmer_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ sv/cmer_ctrl.sv @@
// Sequencer of the event ring: push, start-read and class scan over the record
// and mask RAMs, ring indices, and the result register.
// Depends on cmer_pkg.
`default_nettype none
module cmer_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmer_pkg::cfg_t           cfg,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               command,
	input  wire logic [31:0]              device_addr,
	input  wire logic [7:0]               event_type,
	input  wire logic [7:0]               thing_first,
	input  wire logic [7:0]               thing_second,
	input  wire logic [47:0]              event_clock,
	input  wire logic [7:0]               class_bits,
	input  wire logic [7:0]               class_select,
	input  wire logic                     part_select,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          ok,
	output cmer_pkg::rec_t                out_rec,
	output logic                          is_empty,
	output logic                          need_save,
	output logic                          cycle_done,
	output logic                          mem_we_rec,
	output logic                          mem_we_mask,
	output logic [cmer_pkg::IDX_W-1:0]    mem_waddr,
	output cmer_pkg::rec_t                rec_wdata,
	output cmer_pkg::mask_pair_t          mask_wdata,
	output logic [cmer_pkg::IDX_W-1:0]    mem_raddr,
	input  wire cmer_pkg::rec_t           rec_rdata,
	input  wire cmer_pkg::mask_pair_t     mask_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [cmer_pkg::IDX_W-1:0]        wr_idx_q;
	logic [cmer_pkg::IDX_W-1:0]        rd_idx_q;
	logic [cmer_pkg::IDX_W-1:0]        fill_q;
	logic [cmer_pkg::IDX_W-1:0]        cycle_end_q;
	logic [cmer_pkg::IDX_W-1:0]        cur_q;
	logic [cmer_pkg::STEP_W-1:0]       steps_q;
	cmer_pkg::rec_t                    rec_in_q;
	logic [cmer_pkg::MASK_W-1:0]       mask_in_q;
	logic [7:0]                        cls_q;
	logic                              part_q;
	logic                              ok_q;
	cmer_pkg::rec_t                    res_rec_q;
	logic                              out_valid_q;
	logic                              out_ok_q;
	cmer_pkg::rec_t                    out_rec_q;
	logic                              out_empty_q;
	logic                              out_save_q;
	logic                              out_done_q;

	logic                              eff2;
	logic                              accept;
	logic                              read_ok;
	logic                              not_full;
	logic                              scan_stop;
	logic [cmer_pkg::MASK_W-1:0]       sel_bit;
	logic [cmer_pkg::MASK_W-1:0]       row;
	logic                              hit;
	logic [cmer_pkg::MASK_W-1:0]       first_n;
	logic [cmer_pkg::MASK_W-1:0]       last_n;
	logic [cmer_pkg::MASK_W-1:0]       lastrow_n;
	logic                              retire;
	logic                              out_free;

	assign eff2 = cfg.partition_count[1];
	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);
	assign read_ok = (class_select < 8'(cmer_pkg::CLASSES)) &&
		(cfg.partition_count != '0) && (!part_select || eff2);
	assign not_full = (fill_q < cmer_pkg::IDX_W'(cmer_pkg::DEPTH - 1));
	assign out_free = !out_valid_q || !out_stall;

	assign scan_stop = (cur_q == cycle_end_q) ||
		(steps_q == cmer_pkg::STEP_W'(cmer_pkg::DEPTH));
	assign sel_bit = cmer_pkg::MASK_W'(1) << cls_q;
	assign row = part_q ? mask_rdata.last : mask_rdata.first;
	assign hit = !scan_stop && ((row & sel_bit) != '0);
	assign first_n = (hit && !part_q) ? (mask_rdata.first & ~sel_bit) : mask_rdata.first;
	assign last_n = (hit && part_q) ? (mask_rdata.last & ~sel_bit) : mask_rdata.last;
	assign lastrow_n = eff2 ? last_n : first_n;
	assign retire = !scan_stop && (cur_q == rd_idx_q) && (fill_q != '0) &&
		(first_n == '0) && (lastrow_n == '0);

	always_comb begin
		mem_we_rec = 1'b0;
		mem_we_mask = 1'b0;
		mem_waddr = cur_q;
		rec_wdata = rec_in_q;
		mask_wdata = '0;
		mem_raddr = cmer_pkg::idx_next(cur_q);
		case (state_q)
			ST_CLEAR: begin
				mem_we_mask = 1'b1;
			end
			ST_IDLE: begin
				mem_raddr = (command == cmer_pkg::CMD_PUSH) ? wr_idx_q : rd_idx_q;
			end
			ST_PUSH: begin
				mem_waddr = wr_idx_q;
				mem_we_rec = not_full;
				mem_we_mask = not_full && (mask_in_q != '0);
				mask_wdata.first = mask_in_q;
				mask_wdata.last = eff2 ? mask_in_q : mask_rdata.last;
			end
			ST_SCAN: begin
				mem_we_mask = hit;
				mask_wdata.first = first_n;
				mask_wdata.last = last_n;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q <= '0;
			cycle_end_q <= '0;
			cur_q <= '0;
			steps_q <= '0;
			rec_in_q <= '0;
			mask_in_q <= '0;
			cls_q <= '0;
			part_q <= 1'b0;
			ok_q <= 1'b0;
			res_rec_q <= '0;
			out_valid_q <= 1'b0;
			out_ok_q <= 1'b0;
			out_rec_q <= '0;
			out_empty_q <= 1'b0;
			out_save_q <= 1'b0;
			out_done_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cur_q <= cmer_pkg::idx_next(cur_q);
					if (cur_q == cmer_pkg::IDX_W'(cmer_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						rec_in_q <= '{device: device_addr, etype: event_type,
							first: thing_first, second: thing_second,
							clock: event_clock};
						mask_in_q <= class_bits;
						cls_q <= class_select;
						part_q <= part_select;
						ok_q <= 1'b0;
						res_rec_q <= '0;
						cur_q <= rd_idx_q;
						steps_q <= '0;
						case (command)
							cmer_pkg::CMD_PUSH: begin
								state_q <= ST_PUSH;
							end
							cmer_pkg::CMD_START: begin
								cycle_end_q <= wr_idx_q;
								state_q <= ST_DONE;
							end
							cmer_pkg::CMD_READ: begin
								state_q <= (read_ok && fill_q != '0) ? ST_SCAN : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_PUSH: begin
					if (not_full && mask_in_q != '0) begin
						wr_idx_q <= cmer_pkg::idx_next(wr_idx_q);
						fill_q <= fill_q + 1'b1;
						ok_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					if (scan_stop) begin
						state_q <= ST_DONE;
					end else begin
						if (retire) begin
							rd_idx_q <= cmer_pkg::idx_next(rd_idx_q);
							fill_q <= fill_q - 1'b1;
						end
						if (hit) begin
							ok_q <= 1'b1;
							res_rec_q <= rec_rdata;
							state_q <= ST_DONE;
						end else begin
							cur_q <= cmer_pkg::idx_next(cur_q);
							steps_q <= steps_q + 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_ok_q <= ok_q;
						out_rec_q <= res_rec_q;
						out_empty_q <= (fill_q == '0);
						out_save_q <= (cmer_pkg::CMP_W'(fill_q) >=
							cmer_pkg::CMP_W'(cfg.save_threshold));
						out_done_q <= (rd_idx_q == cycle_end_q);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign ok = out_ok_q;
	assign out_rec = out_rec_q;
	assign is_empty = out_empty_q;
	assign need_save = out_save_q;
	assign cycle_done = out_done_q;

endmodule
`default_nettype wire

@@ sv/class_marked_event_ring_unit.sv @@
// Class-marked event ring: configuration registers, record and mask RAMs,
// and the sequencer. Depends on cmer_pkg, cmer_ram and cmer_ctrl.
// A push passes through a write state before its result; a start-read, a
// refused or empty read goes straight to the result; a scanning read examines
// one ring entry per cycle through the single read port of the mask and
// record RAMs. One item at a time; the next item is taken the cycle after its
// result is loaded.
// After reset the mask RAM is cleared entry by entry while in_stall stays high.
`default_nettype none
module class_marked_event_ring_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [cmer_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cmer_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [1:0]                        command,
	input  wire logic [31:0]                       device_addr,
	input  wire logic [7:0]                        event_type,
	input  wire logic [7:0]                        thing_first,
	input  wire logic [7:0]                        thing_second,
	input  wire logic [47:0]                       event_clock,
	input  wire logic [7:0]                        class_bits,
	input  wire logic [7:0]                        class_select,
	input  wire logic                              part_select,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   ok,
	output logic [31:0]                            out_device,
	output logic [7:0]                             out_type,
	output logic [7:0]                             out_first,
	output logic [7:0]                             out_second,
	output logic [47:0]                            out_clock,
	output logic                                   is_empty,
	output logic                                   need_save,
	output logic                                   cycle_done
);

	cmer_pkg::cfg_t                   cfg_q;
	cmer_pkg::rec_t                   out_rec;
	logic                             mem_we_rec;
	logic                             mem_we_mask;
	logic [cmer_pkg::IDX_W-1:0]       mem_waddr;
	logic [cmer_pkg::IDX_W-1:0]       mem_raddr;
	cmer_pkg::rec_t                   rec_wdata;
	cmer_pkg::rec_t                   rec_rdata;
	cmer_pkg::mask_pair_t             mask_wdata;
	cmer_pkg::mask_pair_t             mask_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.partition_count <= cmer_pkg::PC_W'(2);
			cfg_q.save_threshold <= cmer_pkg::THR_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				cmer_pkg::REG_PARTITION_COUNT: begin
					cfg_q.partition_count <= cfg_data[cmer_pkg::PC_W-1:0];
				end
				cmer_pkg::REG_SAVE_THRESHOLD: begin
					cfg_q.save_threshold <= cfg_data[cmer_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	cmer_ram #(
		.WIDTH($bits(cmer_pkg::rec_t)),
		.DEPTH(cmer_pkg::DEPTH),
		.AW(cmer_pkg::IDX_W)
	) u_rec_ram (
		.clk(clk),
		.we(mem_we_rec),
		.waddr(mem_waddr),
		.wdata(rec_wdata),
		.raddr(mem_raddr),
		.rdata(rec_rdata)
	);

	cmer_ram #(
		.WIDTH($bits(cmer_pkg::mask_pair_t)),
		.DEPTH(cmer_pkg::DEPTH),
		.AW(cmer_pkg::IDX_W)
	) u_mask_ram (
		.clk(clk),
		.we(mem_we_mask),
		.waddr(mem_waddr),
		.wdata(mask_wdata),
		.raddr(mem_raddr),
		.rdata(mask_rdata)
	);

	cmer_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.device_addr(device_addr),
		.event_type(event_type),
		.thing_first(thing_first),
		.thing_second(thing_second),
		.event_clock(event_clock),
		.class_bits(class_bits),
		.class_select(class_select),
		.part_select(part_select),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.ok(ok),
		.out_rec(out_rec),
		.is_empty(is_empty),
		.need_save(need_save),
		.cycle_done(cycle_done),
		.mem_we_rec(mem_we_rec),
		.mem_we_mask(mem_we_mask),
		.mem_waddr(mem_waddr),
		.rec_wdata(rec_wdata),
		.mask_wdata(mask_wdata),
		.mem_raddr(mem_raddr),
		.rec_rdata(rec_rdata),
		.mask_rdata(mask_rdata)
	);

	assign out_device = out_rec.device;
	assign out_type = out_rec.etype;
	assign out_first = out_rec.first;
	assign out_second = out_rec.second;
	assign out_clock = out_rec.clock;

endmodule
`default_nettype wire
